FILE: rtl/core/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// shared types, codes and alphabet functions of the base64 codec core
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FILLS     = 2'd1;
    localparam logic [1:0] ERR_LENGTH    = 2'd2;
    localparam logic [1:0] ERR_BAD_CHAR  = 2'd3;

    localparam logic [7:0] FILL_CHAR = 8'd61;

    // one front-end result group: up to four beats, bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      n_m1;
        logic            last;
        logic [1:0]      err;
    } b64c_job_t;

    typedef struct packed {
        logic full;
        logic valid;
    } b64c_q_status_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
        begin
            r = 8'(8'd65 + {2'b00, v});
        end
        else if (v < 6'd52)
        begin
            r = 8'(8'd71 + {2'b00, v});
        end
        else if (v < 6'd62)
        begin
            r = 8'({2'b00, v} - 8'd4);
        end
        else if (v == 6'd62)
        begin
            r = 8'd43;
        end
        else
        begin
            r = 8'd47;
        end
        return r;
    endfunction

    // bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] dec_sextet(input logic [7:0] ch);
        logic [6:0] r;
        if (ch >= 8'd65 && ch <= 8'd90)
        begin
            r = {1'b0, 6'(ch - 8'd65)};
        end
        else if (ch >= 8'd97 && ch <= 8'd122)
        begin
            r = {1'b0, 6'(ch - 8'd71)};
        end
        else if (ch >= 8'd48 && ch <= 8'd57)
        begin
            r = {1'b0, 6'(ch + 8'd4)};
        end
        else if (ch == 8'd43)
        begin
            r = {1'b0, 6'd62};
        end
        else if (ch == 8'd47)
        begin
            r = {1'b0, 6'd63};
        end
        else
        begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// accepts input beats, keeps the group state and forms result groups
// ----------------------------------------------------------------------------
module b64c_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,
    input  logic                    s_tlast,
    input  b64c_pkg::b64c_q_status_t q_status,
    output logic                    push,
    output b64c_pkg::b64c_job_t     push_job
);
    import b64c_pkg::*;

    logic        mode_reg;
    logic [23:0] group_reg, group_next;
    logic [1:0]  gcount_reg, gcount_next;
    logic [1:0]  total_reg, total_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  elatch_reg, elatch_next;

    logic        accept;
    logic        has_results;
    b64c_job_t   job;
    logic [23:0] g_enc;
    logic [1:0]  cnt_inc;
    logic [23:0] x_tail;
    logic [6:0]  sx;
    logic        completed;
    logic [23:0] g_dec;
    logic [1:0]  err;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && has_results;
    assign push_job = job;

    always_comb
    begin
        group_next  = group_reg;
        gcount_next = gcount_reg;
        total_next  = total_reg;
        fill_next   = fill_reg;
        elatch_next = elatch_reg;
        job         = '0;
        has_results = 1'b0;
        g_enc       = {group_reg[15:0], s_tdata};
        cnt_inc     = 2'(gcount_reg + 2'd1);
        x_tail      = (cnt_inc == 2'd1) ? {s_tdata, 16'h0000} : {g_enc[15:0], 8'h00};
        sx          = dec_sextet(s_tdata);
        completed   = 1'b0;
        g_dec       = group_reg;
        err         = ERR_NONE;

        if (mode_reg == MODE_ENC)
        begin
            group_next  = g_enc;
            gcount_next = cnt_inc;
            if (cnt_inc == 2'd3)
            begin
                job.bytes[0] = enc_char(g_enc[23:18]);
                job.bytes[1] = enc_char(g_enc[17:12]);
                job.bytes[2] = enc_char(g_enc[11:6]);
                job.bytes[3] = enc_char(g_enc[5:0]);
                job.n_m1     = 2'd3;
                job.last     = s_tlast;
                has_results  = 1'b1;
                gcount_next  = 2'd0;
            end
            else if (s_tlast)
            begin
                job.bytes[0] = enc_char(x_tail[23:18]);
                job.bytes[1] = enc_char(x_tail[17:12]);
                job.bytes[2] = (cnt_inc == 2'd2) ? enc_char(x_tail[11:6]) : FILL_CHAR;
                job.bytes[3] = FILL_CHAR;
                job.n_m1     = 2'd3;
                job.last     = 1'b1;
                has_results  = 1'b1;
            end
        end
        else
        begin
            if (s_tdata == FILL_CHAR)
            begin
                if (fill_reg != 2'd3)
                begin
                    fill_next = 2'(fill_reg + 2'd1);
                end
            end
            else if (fill_reg != 2'd0 || sx[6])
            begin
                elatch_next = ERR_BAD_CHAR;
            end
            else
            begin
                g_dec       = {group_reg[17:0], sx[5:0]};
                group_next  = g_dec;
                gcount_next = cnt_inc;
                completed   = (gcount_reg == 2'd3);
            end
            total_next = 2'(total_reg + 2'd1);

            if (fill_next == 2'd3)
            begin
                err = ERR_FILLS;
            end
            else if (total_next != 2'd0)
            begin
                err = ERR_LENGTH;
            end
            else
            begin
                err = elatch_next;
            end

            if (!s_tlast)
            begin
                job.bytes[0] = g_dec[23:16];
                job.bytes[1] = g_dec[15:8];
                job.bytes[2] = g_dec[7:0];
                job.n_m1     = 2'd2;
                has_results  = completed && (elatch_next == ERR_NONE);
            end
            else
            begin
                has_results = 1'b1;
                job.last    = 1'b1;
                if (err != ERR_NONE)
                begin
                    job.err = err;
                end
                else if (completed)
                begin
                    job.bytes[0] = g_dec[23:16];
                    job.bytes[1] = g_dec[15:8];
                    job.bytes[2] = g_dec[7:0];
                    job.n_m1     = 2'd2;
                end
                else if (fill_next == 2'd1)
                begin
                    job.bytes[0] = g_dec[17:10];
                    job.bytes[1] = g_dec[9:2];
                    job.n_m1     = 2'd1;
                end
                else
                begin
                    job.bytes[0] = g_dec[11:4];
                end
            end
        end

        if (s_tlast)
        begin
            group_next  = '0;
            gcount_next = '0;
            total_next  = '0;
            fill_next   = '0;
            elatch_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ENC;
            group_reg  <= '0;
            gcount_reg <= '0;
            total_reg  <= '0;
            fill_reg   <= '0;
            elatch_reg <= ERR_NONE;
        end
        else if (cfg_we)
        begin
            mode_reg   <= cfg_wdata;
            group_reg  <= '0;
            gcount_reg <= '0;
            total_reg  <= '0;
            fill_reg   <= '0;
            elatch_reg <= ERR_NONE;
        end
        else if (accept)
        begin
            group_reg  <= group_next;
            gcount_reg <= gcount_next;
            total_reg  <= total_next;
            fill_reg   <= fill_next;
            elatch_reg <= elatch_next;
        end
    end

    a_enc_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (push && mode_reg == MODE_ENC) |-> (push_job.err == ERR_NONE))
        else $error("encode group carries an error code");

endmodule

FILE: rtl/core/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue
// short fifo of result groups between front and back
// ----------------------------------------------------------------------------
module b64c_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  b64c_pkg::b64c_job_t      push_job,
    input  logic                     pop,
    output b64c_pkg::b64c_job_t      pop_job,
    output b64c_pkg::b64c_q_status_t q_status
);
    import b64c_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64c_job_t         mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.valid = (count_reg != '0);
    assign pop_job        = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// takes result groups from the queue and sends them out one beat at a time
// ----------------------------------------------------------------------------
module b64c_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  b64c_pkg::b64c_q_status_t q_status,
    input  b64c_pkg::b64c_job_t      pop_job,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    output logic [1:0]               m_tuser
);
    import b64c_pkg::*;

    b64c_job_t  job_reg;
    logic       busy_reg;
    logic [1:0] beat_reg;
    logic       fire;
    logic       final_beat;

    assign final_beat = (beat_reg == job_reg.n_m1);
    assign fire       = busy_reg && m_tready;
    assign pop        = q_status.valid && (!busy_reg || (fire && final_beat));

    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.bytes[beat_reg];
    assign m_tlast  = job_reg.last && final_beat;
    assign m_tuser  = job_reg.err;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            beat_reg <= '0;
        end
        else if (fire && final_beat)
        begin
            busy_reg <= 1'b0;
        end
        else if (fire)
        begin
            beat_reg <= 2'(beat_reg + 2'd1);
        end
    end

    a_err_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ERR_NONE) |-> m_tlast)
        else $error("error code on a beat that is not last");

endmodule

FILE: rtl/core/base64_codec_core.sv
// ----------------------------------------------------------------------------
// base64_codec_core
// streaming base64 encoder / decoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// results pass the queue and the back-end job register before going out
// throughput: one output beat per cycle while m_tready is high; an input beat
// yields 0 to 4 output beats; encode turns three input bytes into four beats
// s_tready drops while the result queue (QUEUE_DEPTH groups) is full
// reset: rst_n clears mode to encode, all message state and the queue at once
module base64_codec_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,   // mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser      // error
);
    import b64c_pkg::*;

    b64c_q_status_t q_status;
    b64c_job_t      push_job;
    b64c_job_t      pop_job;
    logic           push;
    logic           pop;

    b64c_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    b64c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .pop_job   (pop_job),
        .q_status  (q_status)
    );

    b64c_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_job   (pop_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
